// ===== hw/rtl/hbsf_pkg.sv =====
package hbsf_pkg;

	// flag, crc and stuffing constants
	localparam logic [7:0]  FLAG     = 8'h7E;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [2:0]  MAX_ONES = 3'd5;

	// one accepted payload byte, classified by the front
	typedef struct packed {
		logic        open;   // byte opens a frame
		logic [7:0]  data;
		logic        last;   // byte closes a frame
		logic [31:0] crc;    // inverted crc after this byte
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} res_t;

endpackage

// ===== hw/rtl/hdlc_bit_stuff_framer_crc32.sv =====
// hdlc framer with bit stuffing and crc-32
//
// input channel: one payload byte per item on data_byte, last marks the final
//   byte of a frame; an item is taken on a rising edge with push high and full low
// result channel: one frame byte per item on frame_byte, frame_end high on the
//   closing flag; the oldest item is shown while empty is low and taken on pop
// the front classifies each item and folds it into the running crc, a small
//   command queue hands it to the back, which stuffs one nibble per cycle into
//   a result queue while a command waits and the result queue has room
// per frame: the back takes each payload byte as its high and low nibble, sends
//   the opening flag before a frame's first byte, and after the last byte stuffs
//   the 8 crc nibbles, then the pad and the closing flag; the nibble stuffer sets the pace
// path: with both queues empty and the back idle, an opening flag goes from the
//   command queue through the back into the result queue before it is visible;
//   a stuffed byte completed by the item's high or low nibble takes the same path
// reset: both queues empty, crc all ones, no frame open, stuffer cleared
// receiver stall: results back up in the result queue, the back halts, then the
//   command queue fills and full rises; nothing is dropped
module hdlc_bit_stuff_framer_crc32 #(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] frame_byte,
	output logic       frame_end
);

	import hbsf_pkg::*;

	logic accept;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_empty;
	logic cmd_pop;
	logic res_push;
	res_t res_in;
	res_t res_head;
	logic res_full;

	// item taken when queue has room
	assign accept = push && !full;

	hbsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last      (last),
		.cmd       (cmd_in)
	);

	// classified items wait here for the stuffer
	hbsf_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	hbsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// result queue parts the stuffer from the receiver
	hbsf_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign frame_byte = res_head.frame_byte;
	assign frame_end  = res_head.frame_end;

endmodule

// ===== hw/rtl/hbsf_fifo.sv =====
module hbsf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/hbsf_front.sv =====
module hbsf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          last,
	output hbsf_pkg::cmd_t cmd
);

	import hbsf_pkg::*;

	logic [31:0] crc_q;
	logic        in_frame_q;
	logic [31:0] crc_base;
	logic [31:0] crc_next;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] v);
		logic [31:0] r;
		r = c ^ {24'b0, v};
		for (int j = 0; j < 8; j++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	always_comb begin
		crc_base  = in_frame_q ? crc_q : CRC_INIT;
		crc_next  = crc_byte(crc_base, data_byte);
		cmd.open  = !in_frame_q;
		cmd.data  = data_byte;
		cmd.last  = last;
		cmd.crc   = ~crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				crc_q      <= CRC_INIT;
				in_frame_q <= 1'b0;
			end else begin
				crc_q      <= crc_next;
				in_frame_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/hbsf_back.sv =====
module hbsf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hbsf_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	output logic           res_push,
	output hbsf_pkg::res_t res,
	input  logic           res_full
);

	import hbsf_pkg::*;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_OPEN  = 3'd1;
	localparam logic [2:0] PH_NIB   = 3'd2;
	localparam logic [2:0] PH_PAD   = 3'd3;
	localparam logic [2:0] PH_CLOSE = 3'd4;

	localparam logic [3:0] NIB_DATA_LO = 4'd1;
	localparam logic [3:0] NIB_LAST    = 4'd9;

	typedef struct packed {
		logic [4:0] bits;  // appended bits, right aligned
		logic [2:0] cnt;
		logic [2:0] run;
	} stf_t;

	logic [2:0]  ph_q, ph_d, eff_ph;
	logic [3:0]  nib_q, nib_d;
	logic [2:0]  run_q, run_d;
	logic [7:0]  acc_q, acc_d;
	logic [2:0]  fill_q, fill_d;
	logic        go;
	logic [39:0] seq;
	logic [39:0] seq_sh;
	logic [3:0]  nib;
	stf_t        st;
	logic [4:0]  aligned;
	logic [15:0] w;
	logic [3:0]  total;

	// four bits msb first through the stuffer
	function automatic stf_t stuff_nibble(input logic [3:0] n, input logic [2:0] run);
		stf_t s;
		s.bits = '0;
		s.cnt  = '0;
		s.run  = run;
		for (int i = 3; i >= 0; i--) begin
			s.bits = {s.bits[3:0], n[i]};
			s.cnt  = s.cnt + 3'd1;
			s.run  = n[i] ? s.run + 3'd1 : 3'd0;
			if (s.run == MAX_ONES) begin
				s.bits = {s.bits[3:0], 1'b0};
				s.cnt  = s.cnt + 3'd1;
				s.run  = 3'd0;
			end
		end
		return s;
	endfunction

	always_comb begin
		go     = !cmd_empty && !res_full;
		eff_ph = (ph_q == PH_START) ? (cmd.open ? PH_OPEN : PH_NIB) : ph_q;

		// data byte then crc bytes low first, each high nibble first
		seq    = {cmd.data, cmd.crc[7:0], cmd.crc[15:8], cmd.crc[23:16], cmd.crc[31:24]};
		seq_sh = seq << {nib_q, 2'b00};
		nib    = seq_sh[39:36];

		st      = stuff_nibble(nib, run_q);
		aligned = st.bits << (3'd5 - st.cnt);
		w       = {acc_q, 8'b0} | ({aligned, 11'b0} >> fill_q);
		total   = {1'b0, fill_q} + {1'b0, st.cnt};

		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		ph_d     = ph_q;
		nib_d    = nib_q;
		run_d    = run_q;
		acc_d    = acc_q;
		fill_d   = fill_q;

		if (go) begin
			case (eff_ph)
				PH_OPEN: begin
					res_push       = 1'b1;
					res.frame_byte = FLAG;
					run_d          = '0;
					acc_d          = '0;
					fill_d         = '0;
					ph_d           = PH_NIB;
					nib_d          = '0;
				end
				PH_NIB: begin
					run_d  = st.run;
					fill_d = total[2:0];
					if (total[3]) begin
						res_push       = 1'b1;
						res.frame_byte = w[15:8];
						acc_d          = w[7:0];
					end else begin
						acc_d = w[15:8];
					end
					if (nib_q == NIB_DATA_LO && !cmd.last) begin
						cmd_pop = 1'b1;
						ph_d    = PH_START;
						nib_d   = '0;
					end else if (nib_q == NIB_LAST) begin
						ph_d  = PH_PAD;
						nib_d = '0;
					end else begin
						ph_d  = PH_NIB;
						nib_d = nib_q + 4'd1;
					end
				end
				PH_PAD: begin
					// partial byte already zero in its low bits
					if (fill_q != '0) begin
						res_push       = 1'b1;
						res.frame_byte = acc_q;
					end
					ph_d = PH_CLOSE;
				end
				PH_CLOSE: begin
					res_push       = 1'b1;
					res.frame_byte = FLAG;
					res.frame_end  = 1'b1;
					run_d          = '0;
					acc_d          = '0;
					fill_d         = '0;
					cmd_pop        = 1'b1;
					ph_d           = PH_START;
					nib_d          = '0;
				end
				default: begin
					ph_d  = PH_START;
					nib_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_START;
			nib_q  <= '0;
			run_q  <= '0;
			acc_q  <= '0;
			fill_q <= '0;
		end else begin
			ph_q   <= ph_d;
			nib_q  <= nib_d;
			run_q  <= run_d;
			acc_q  <= acc_d;
			fill_q <= fill_d;
		end
	end

endmodule

// ===== hw/rtl/hbsf_checker.sv =====
module hbsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] frame_byte,
	input logic       frame_end
);

	import hbsf_pkg::*;

	logic open_q;

	// tracks whether the receiver is inside a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (pop && !empty) begin
			open_q <= !frame_end;
		end
	end

	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty during reset");

	a_end_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> (frame_byte == FLAG))
		else $error("frame end on a byte that is not a flag");

	a_opens_with_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !open_q) |-> (frame_byte == FLAG && !frame_end))
		else $error("frame does not open with a flag");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(frame_end)))
		else $error("stalled result item changed");

endmodule

bind hdlc_bit_stuff_framer_crc32 hbsf_checker u_chk (.*);

// ===== tb/hdlc_bit_stuff_framer_crc32_tb.sv =====
`timescale 1ns / 1ps

module hdlc_bit_stuff_framer_crc32_tb;
	import hbsf_pkg::*;

	// framer model: tracks the open frame, the running crc and the stuffer,
	// and keeps the frame bytes that the block still owes us
	class frame_scoreboard;
		logic [31:0] crc;
		logic [2:0]  ones_run;
		logic [7:0]  bit_accum;
		logic [2:0]  bit_fill;
		logic        frame_open;
		res_t        frame_bytes_due[$];
		int          errors;
		int          payload_bytes;
		int          frame_bytes;
		int          frames;
		int          stuffed_zeros;

		function new();
			clear_frame();
			frame_open = 1'b0;
			errors = 0;
			payload_bytes = 0;
			frame_bytes = 0;
			frames = 0;
			stuffed_zeros = 0;
		endfunction

		// fresh crc and an empty stuffer, as at frame start and after closing
		function void clear_frame();
			crc = CRC_INIT;
			ones_run = 3'd0;
			bit_accum = 8'd0;
			bit_fill = 3'd0;
		endfunction

		function void owe_byte(logic [7:0] b, logic e);
			frame_bytes_due.push_back({b, e});
		endfunction

		// output byte fills from its msb; a full byte is owed right away
		function void put_bit(logic b);
			bit_accum[3'd7 - bit_fill] = b;
			if (bit_fill == 3'd7) begin
				owe_byte(bit_accum, 1'b0);
				bit_accum = 8'd0;
				bit_fill = 3'd0;
			end else begin
				bit_fill++;
			end
		endfunction

		// msb first, a zero after every fifth one in a row
		function void stuff_byte(logic [7:0] v);
			for (int i = 7; i >= 0; i--) begin
				put_bit(v[i]);
				if (v[i])
					ones_run++;
				else
					ones_run = 3'd0;
				if (ones_run == MAX_ONES) begin
					put_bit(1'b0);
					ones_run = 3'd0;
					stuffed_zeros++;
				end
			end
		endfunction

		// one accepted payload byte: work out every frame byte it causes
		function void take_payload(logic [7:0] d, logic l);
			logic [31:0] fcs;
			payload_bytes++;
			if (!frame_open) begin
				clear_frame();
				frame_open = 1'b1;
				owe_byte(FLAG, 1'b0);
			end
			// reflected crc-32, one bit per step
			crc = crc ^ {24'd0, d};
			for (int j = 0; j < 8; j++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			stuff_byte(d);
			if (l) begin
				// inverted crc goes out low byte first through the same stuffer
				fcs = ~crc;
				for (int k = 0; k < 4; k++)
					stuff_byte(fcs[8*k +: 8]);
				// partial byte goes out with its low bits zero
				if (bit_fill != 3'd0)
					owe_byte(bit_accum, 1'b0);
				owe_byte(FLAG, 1'b1);
				clear_frame();
				frame_open = 1'b0;
				frames++;
			end
		endfunction

		function void check_frame_byte(logic [7:0] b, logic e);
			res_t want;
			frame_bytes++;
			if (frame_bytes_due.size() == 0) begin
				$error("frame_byte %h frame_end %b with nothing outstanding", b, e);
				errors++;
				return;
			end
			want = frame_bytes_due.pop_front();
			if (b !== want.frame_byte) begin
				$error("frame_byte: expected %h, got %h", want.frame_byte, b);
				errors++;
			end
			if (e !== want.frame_end) begin
				$error("frame_end: expected %b, got %b", want.frame_end, e);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       last;
	logic       empty;
	logic       pop;
	logic [7:0] frame_byte;
	logic       frame_end;

	frame_scoreboard sb;

	// idling knobs: percent chance of a burst before each item or each pop,
	// and a quiet flag that shuts idling off for the closing stretch
	int         send_idle_pct;
	int         pop_idle_pct;
	bit         quiet;
	int         items_sent;

	hdlc_bit_stuff_framer_crc32 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last      (last),
		.empty     (empty),
		.pop       (pop),
		.frame_byte(frame_byte),
		.frame_end (frame_end)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop well past the slowest correct run
	// (up to 435 items, each with max gap, 10 frame bytes, each behind a max stall)
	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// idle burst length before the next item or pop, 0 for none
	function automatic int idle_burst(int pct);
		if (quiet || pct == 0)
			return 0;
		if ($urandom_range(99) < pct)
			return $urandom_range(1, 13);
		return 0;
	endfunction

	// hold push low for the gap, then offer the byte until full drops;
	// the next call keeps push high when there is no gap
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = idle_burst(send_idle_pct);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		data_byte <= b;
		last <= l;
		do
			@(posedge clk);
		while (full);
		sb.take_payload(b, l);
		items_sent++;
	endtask

	// payload bias: all ones and flag patterns stress the stuffer
	function automatic logic [7:0] pick_payload();
		case ($urandom_range(7))
			0, 1:    return 8'hFF;
			2:       return FLAG;
			3:       return {$urandom_range(1) ? 3'b111 : 3'b000, 5'b11111};
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_byte(pick_payload(), i == len - 1);
	endtask

	// receiver: pop high unless inside a stall burst
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0)
				stall = idle_burst(pop_idle_pct);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// every frame byte taken is checked against the oldest one owed
	always @(posedge clk)
		if (arst_n && pop && !empty)
			sb.check_frame_byte(frame_byte, frame_end);

	// directed openers: edge payloads, single-byte frames, ones runs that
	// cross byte boundaries, flag patterns inside payload
	logic [8:0] opening_items [17] = '{
		{1'b1, 8'h00},
		{1'b1, 8'hFF},
		{1'b1, 8'h7E},
		{1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
		{1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, 8'h01}, {1'b0, 8'h55}, {1'b1, 8'hAA},
		{1'b0, 8'h1F}, {1'b1, 8'hF8},
		{1'b0, 8'h7E}, {1'b0, 8'h7F}, {1'b1, 8'hFE}
	};

	initial begin
		int len;
		int drain;
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'd0;
		last = 1'b0;
		quiet = 1'b0;
		send_idle_pct = 20;
		pop_idle_pct = 20;
		items_sent = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_items[i])
			send_byte(opening_items[i][7:0], opening_items[i][8]);

		// random frames, mostly short, now and then a long one; idling
		// intensity is redrawn before about one frame in four, so some stretches run flat out
		while (items_sent < 420) begin
			if (items_sent > 360)
				quiet = 1'b1;
			if ($urandom_range(3) == 0) begin
				send_idle_pct = $urandom_range(2) * 25;
				pop_idle_pct = $urandom_range(2) * 25;
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
			send_frame(len);
		end
		@(negedge clk);
		push <= 1'b0;

		// wait until everything owed has come out, then a little longer
		// for anything unexpected trailing behind
		while (sb.frame_bytes_due.size() != 0)
			@(posedge clk);
		for (drain = 0; drain < 30; drain++)
			@(posedge clk);
		if (sb.frame_bytes_due.size() != 0) begin
			$error("%0d frame bytes never arrived", sb.frame_bytes_due.size());
			sb.errors++;
		end

		$display("covered %0d frames from %0d payload bytes, %0d frame bytes checked",
			sb.frames, sb.payload_bytes, sb.frame_bytes);
		$display("stuffer inserted %0d zero bits across payload and crc", sb.stuffed_zeros);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== hdlc_bit_stuff_framer_crc32.f =====
hw/rtl/hbsf_pkg.sv
hw/rtl/hbsf_fifo.sv
hw/rtl/hbsf_front.sv
hw/rtl/hbsf_back.sv
hw/rtl/hdlc_bit_stuff_framer_crc32.sv
hw/rtl/hbsf_checker.sv
tb/hdlc_bit_stuff_framer_crc32_tb.sv
